// ----- rtl/modexp_pkg.sv -----
package modexp_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);
   localparam int PC_W  = 4;

   typedef struct packed {
      logic [WIDTH-1:0] base;
      logic [WIDTH-1:0] exponent;
      logic [WIDTH-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [WIDTH-1:0] power_mod;
      logic             zero_modulus;
   } rsp_type;

   // datapath action of one microcode step
   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_LOAD,
      ACT_INIT,
      ACT_MUL_STEP,
      ACT_SET_BASE,
      ACT_SETUP_SQ,
      ACT_SETUP_ML,
      ACT_TAKE,
      ACT_EXP_DEC,
      ACT_EMIT
   } act_type;

   // jump condition; jump to target when true, else fall through
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_MOD_ZERO,
      COND_CNT_NZ,
      COND_EBIT_ZERO,
      COND_ECNT_NZ,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      act_type         act;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } uword_type;

   localparam logic [PC_W-1:0] PC_WAIT    = PC_W'(0);
   localparam logic [PC_W-1:0] PC_INIT    = PC_W'(1);
   localparam logic [PC_W-1:0] PC_RED     = PC_W'(2);
   localparam logic [PC_W-1:0] PC_SETB    = PC_W'(3);
   localparam logic [PC_W-1:0] PC_SQ_SET  = PC_W'(4);
   localparam logic [PC_W-1:0] PC_SQ_MUL  = PC_W'(5);
   localparam logic [PC_W-1:0] PC_SQ_TAKE = PC_W'(6);
   localparam logic [PC_W-1:0] PC_ML_SET  = PC_W'(7);
   localparam logic [PC_W-1:0] PC_ML_MUL  = PC_W'(8);
   localparam logic [PC_W-1:0] PC_ML_TAKE = PC_W'(9);
   localparam logic [PC_W-1:0] PC_ADV     = PC_W'(10);
   localparam logic [PC_W-1:0] PC_OUT     = PC_W'(11);
   localparam logic [PC_W-1:0] PC_BACK    = PC_W'(12);

   // microprogram
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      case (pc)
         PC_WAIT:    w = '{ACT_LOAD,     COND_NO_REQ,    PC_WAIT};
         PC_INIT:    w = '{ACT_INIT,     COND_MOD_ZERO,  PC_OUT};
         PC_RED:     w = '{ACT_MUL_STEP, COND_CNT_NZ,    PC_RED};
         PC_SETB:    w = '{ACT_SET_BASE, COND_NEVER,     PC_WAIT};
         PC_SQ_SET:  w = '{ACT_SETUP_SQ, COND_NEVER,     PC_WAIT};
         PC_SQ_MUL:  w = '{ACT_MUL_STEP, COND_CNT_NZ,    PC_SQ_MUL};
         PC_SQ_TAKE: w = '{ACT_TAKE,     COND_EBIT_ZERO, PC_ADV};
         PC_ML_SET:  w = '{ACT_SETUP_ML, COND_NEVER,     PC_WAIT};
         PC_ML_MUL:  w = '{ACT_MUL_STEP, COND_CNT_NZ,    PC_ML_MUL};
         PC_ML_TAKE: w = '{ACT_TAKE,     COND_NEVER,     PC_WAIT};
         PC_ADV:     w = '{ACT_EXP_DEC,  COND_ECNT_NZ,   PC_SQ_SET};
         PC_OUT:     w = '{ACT_EMIT,     COND_OUT_BUSY,  PC_OUT};
         PC_BACK:    w = '{ACT_NOP,      COND_ALWAYS,    PC_WAIT};
         default:    w = '{ACT_NOP,      COND_ALWAYS,    PC_WAIT};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/modular_exponentiation_unit.sv -----
// channel  direction  handshake           payload
// req      in         req_valid/req_stall  req_data (base, exponent, modulus)
// rsp      out        rsp_valid/rsp_stall  rsp_data (power_mod, zero_modulus)
//
// one transaction at a time; a microcoded sequencer drives one modular
// shift-and-add multiply step per cycle, and an exponent bit of zero skips its
// multiply, so such a transaction finishes sooner
// a zero modulus jumps from the init step straight to the output step and returns with zero_modulus set
// reset is synchronous and returns the sequencer to its wait step
// the result register lets the next transaction start while rsp is stalled
module modular_exponentiation_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  modexp_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output modexp_pkg::rsp_type  rsp_data
);

   localparam int W  = modexp_pkg::WIDTH;
   localparam int CW = modexp_pkg::CNT_W;
   localparam int PW = modexp_pkg::PC_W;

   logic [PW-1:0] pc_ff, pc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   modexp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [W-1:0]  base_ff, base_in;
   logic [W-1:0]  exp_ff, exp_in;
   logic [W-1:0]  mod_ff, mod_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  bred_ff, bred_in;
   logic [W-1:0]  mx_ff, mx_in;
   logic [W-1:0]  my_ff, my_in;
   logic [W-1:0]  prod_ff, prod_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] ecnt_ff, ecnt_in;
   logic          zmod_ff, zmod_in;

   modexp_pkg::uword_type uw;
   logic          cond_true;
   logic          out_busy;
   logic [W-1:0]  one_mod;
   logic [W:0]    dbl;
   logic [W-1:0]  dbl_red;
   logic [W:0]    sum;
   logic [W-1:0]  sum_red;

   assign uw        = modexp_pkg::ucode_rom(pc_ff);
   assign req_stall = (pc_ff != modexp_pkg::PC_WAIT);
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // 1 mod m, also zero for a zero modulus
   assign one_mod = (mod_ff > W'(1)) ? W'(1) : '0;

   // one step of the shift-and-add modular multiply
   always_comb begin
      dbl     = {prod_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, mod_ff}) ? W'(dbl - {1'b0, mod_ff}) : dbl[W-1:0];
      sum     = {1'b0, dbl_red} + (my_ff[cnt_ff] ? {1'b0, mx_ff} : '0);
      sum_red = (sum >= {1'b0, mod_ff}) ? W'(sum - {1'b0, mod_ff}) : sum[W-1:0];
   end

   // jump condition and next step
   always_comb begin
      case (uw.cond)
         modexp_pkg::COND_NEVER:     cond_true = 1'b0;
         modexp_pkg::COND_ALWAYS:    cond_true = 1'b1;
         modexp_pkg::COND_NO_REQ:    cond_true = !req_valid;
         modexp_pkg::COND_MOD_ZERO:  cond_true = (mod_ff == '0);
         modexp_pkg::COND_CNT_NZ:    cond_true = (cnt_ff != '0);
         modexp_pkg::COND_EBIT_ZERO: cond_true = !exp_ff[ecnt_ff];
         modexp_pkg::COND_ECNT_NZ:   cond_true = (ecnt_ff != '0);
         modexp_pkg::COND_OUT_BUSY:  cond_true = out_busy;
         default:                    cond_true = 1'b0;
      endcase
      pc_in = cond_true ? uw.target : PW'(pc_ff + PW'(1));
   end

   // datapath actions
   always_comb begin
      base_in      = base_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      acc_in       = acc_ff;
      bred_in      = bred_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      ecnt_in      = ecnt_ff;
      zmod_in      = zmod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (uw.act)
         modexp_pkg::ACT_LOAD: begin
            if (req_valid) begin
               base_in = req_data.base;
               exp_in  = req_data.exponent;
               mod_in  = req_data.modulus;
               zmod_in = (req_data.modulus == '0);
            end
         end
         modexp_pkg::ACT_INIT: begin
            acc_in  = one_mod;
            mx_in   = one_mod;
            my_in   = base_ff;
            prod_in = '0;
            cnt_in  = CW'(W - 1);
         end
         modexp_pkg::ACT_MUL_STEP: begin
            prod_in = sum_red;
            cnt_in  = CW'(cnt_ff - CW'(1));
         end
         modexp_pkg::ACT_SET_BASE: begin
            bred_in = prod_ff;
            ecnt_in = CW'(W - 1);
         end
         modexp_pkg::ACT_SETUP_SQ: begin
            mx_in   = acc_ff;
            my_in   = acc_ff;
            prod_in = '0;
            cnt_in  = CW'(W - 1);
         end
         modexp_pkg::ACT_SETUP_ML: begin
            mx_in   = acc_ff;
            my_in   = bred_ff;
            prod_in = '0;
            cnt_in  = CW'(W - 1);
         end
         modexp_pkg::ACT_TAKE: begin
            acc_in = prod_ff;
         end
         modexp_pkg::ACT_EXP_DEC: begin
            ecnt_in = CW'(ecnt_ff - CW'(1));
         end
         modexp_pkg::ACT_EMIT: begin
            if (!out_busy) begin
               rsp_data_in.power_mod    = acc_ff;
               rsp_data_in.zero_modulus = zmod_ff;
               rsp_valid_in             = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= modexp_pkg::PC_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      mod_ff      <= mod_in;
      acc_ff      <= acc_in;
      bred_ff     <= bred_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      prod_ff     <= prod_in;
      cnt_ff      <= cnt_in;
      ecnt_ff     <= ecnt_in;
      zmod_ff     <= zmod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
